// ===== rtl/core/atp_pkg.sv =====
`default_nettype none

package atp_pkg;

  localparam int NOW_W       = 32;
  localparam int REQ_W       = 24;
  localparam int RATE_W      = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DAT_W   = 32;
  localparam int MUL_W       = 32;
  localparam int PROD_W      = 72;
  localparam int US_Q8_W     = 28;
  localparam int US_Q8_SHIFT = 14;
  localparam int REC_SHIFT   = 45;
  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = 1;
  localparam int Q_CNT_W     = 2;

  localparam logic [US_Q8_W-1:0]   US_Q8               = 28'd256000000;
  localparam logic [US_Q8_W-1:0]   US_Q8_HALF          = 28'd128000000;
  localparam logic [13:0]          US_Q8_ODD           = 14'd15625;
  localparam logic [MUL_W-1:0]     REC_C               = 32'd2251799813;
  localparam logic [NOW_W-1:0]     INTERVAL_RESET      = 32'd10000;
  localparam logic [REQ_W-1:0]     INIT_REQUIRED_RESET = 24'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_US      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_REQUIRED = 2'd1;

  typedef struct packed {
    logic             mode;
    logic [NOW_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic              is_ready;
    logic [REQ_W-1:0]  required_count;
    logic [RATE_W-1:0] rate_estimate;
  } out_item_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_REARM = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [NOW_W-1:0] now_time;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/atp_front.sv =====
`default_nettype none

module atp_front
  import atp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire in_item_t in_item,
  output logic          in_full,
  output logic          q_valid,
  output cmd_t          q_cmd,
  input  wire logic     q_pop
);

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_wr;
  logic               do_rd;
  cmd_t               wr_cmd;

  assign in_full = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = slot_r[rd_ptr_r];
  assign do_wr   = in_push && !in_full;
  assign do_rd   = q_pop && q_valid;

  always_comb begin
    wr_cmd.kind     = in_item.mode ? CMD_REARM : CMD_TICK;
    wr_cmd.now_time = in_item.now_time;
    wr_ptr_nxt      = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt      = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt         = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/atp_div.sv =====
`default_nettype none

module atp_div
  import atp_pkg::*;
#(
  parameter int NUM_W = 88,
  parameter int DEN_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [RATE_W-1:0]     quo
);

  localparam int HI_W  = NUM_W - RATE_W;
  localparam int CNT_W = $clog2(RATE_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [RATE_W-1:0] acc_r, acc_nxt;
  logic [HI_W-1:0]   num_hi;
  logic [DEN_W:0]    trial;
  logic              ge;

  assign done   = done_r;
  assign quo    = acc_r;
  assign num_hi = num[NUM_W-1:RATE_W];
  assign trial  = {rem_r, acc_r[RATE_W-1]};
  assign ge     = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    acc_nxt  = acc_r;
    if (start) begin
      den_nxt = den;
      if (num_hi >= HI_W'(den)) begin
        acc_nxt  = '1;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = num_hi[DEN_W-1:0];
        acc_nxt  = num[RATE_W-1:0];
        cnt_nxt  = CNT_W'(RATE_W);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      acc_nxt = {acc_r[RATE_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    acc_r <= acc_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/atp_back.sv =====
`default_nettype none

module atp_back
  import atp_pkg::*;
#(
  parameter int COUNT_WIDTH = 24,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire cmd_t                 q_cmd,
  output logic                      q_pop,
  output out_item_t                 out_item,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int DEN_W  = (TIME_WIDTH > US_Q8_W) ? TIME_WIDTH : US_Q8_W;
  localparam int DIV_NW = (PROD_W > RATE_W + DEN_W) ? PROD_W : RATE_W + DEN_W;
  localparam int M_W    = PROD_W - US_Q8_SHIFT;
  localparam int REC_W  = 3 * MUL_W;

  localparam logic [M_W-1:0]         ODD_1    = M_W'(US_Q8_ODD);
  localparam logic [M_W-1:0]         ODD_2    = ODD_1 << 1;
  localparam logic [M_W-1:0]         SAT_LIM  = ODD_1 << COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] NEED_MAX = '1;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_MUL_T = 8'b00000010,
    ST_DIV_R = 8'b00000100,
    ST_MUL_L = 8'b00001000,
    ST_MUL_H = 8'b00010000,
    ST_REC_L = 8'b00100000,
    ST_REC_H = 8'b01000000,
    ST_FIX   = 8'b10000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [COUNT_WIDTH-1:0] need_r, need_nxt;
  logic [RATE_W-1:0]      rate_r, rate_nxt;
  logic [TIME_WIDTH-1:0]  last_r, last_nxt;
  logic                   first_r, first_nxt;
  logic [NOW_W-1:0]       interval_r, interval_nxt;
  logic                   res_valid_r, res_valid_nxt;
  logic                   div_go_r, div_go_nxt;
  out_item_t              res_r, res_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [TIME_WIDTH-1:0]  elapsed_r, elapsed_nxt;
  logic [2*MUL_W-1:0]     rec_r, rec_nxt;
  logic [MUL_W-1:0]       est_r, est_nxt;

  logic [TIME_WIDTH-1:0]  now_cut;
  logic                   take;
  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [2*MUL_W-1:0]     mul_p;
  logic [RATE_W+2:0]      blend_sum;
  logic [DEN_W-1:0]       div_den;
  logic                   div_done;
  logic [RATE_W-1:0]      div_quo;
  logic [M_W-1:0]         m_val;
  logic                   m_sat;
  logic [REC_W-1:0]       rec_sum;
  logic [M_W-1:0]         fix_rem;
  logic [1:0]             fix_step;
  logic [COUNT_WIDTH-1:0] need_calc;

  assign out_item  = res_r;
  assign out_empty = !res_valid_r;
  assign now_cut   = TIME_WIDTH'(q_cmd.now_time);
  assign take      = q_valid && (!res_valid_r || out_pop);
  assign q_pop     = (state_r == ST_IDLE) && take;
  assign mul_p     = mul_a * mul_b;
  assign div_den   = DEN_W'(elapsed_r);
  assign blend_sum = {3'b000, rate_r} + {3'b000, div_quo} + {2'b00, div_quo, 1'b0};
  assign m_val     = prod_r[PROD_W-1:US_Q8_SHIFT];
  assign m_sat     = (m_val >= SAT_LIM);
  assign rec_sum   = REC_W'(rec_r) + (REC_W'(mul_p) << MUL_W);
  assign fix_rem   = m_val - M_W'(mul_p);
  assign fix_step  = (fix_rem >= ODD_2) ? 2'd2 : ((fix_rem >= ODD_1) ? 2'd1 : 2'd0);
  assign need_calc = COUNT_WIDTH'(est_r + MUL_W'(fix_step));

  atp_div #(
    .NUM_W (DIV_NW),
    .DEN_W (DEN_W)
  ) u_atp_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (DIV_NW'(prod_r)),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_T: begin
        mul_a = MUL_W'(tick_r);
        mul_b = MUL_W'(US_Q8);
      end
      ST_MUL_L: begin
        mul_a = rate_r[MUL_W-1:0];
        mul_b = interval_r;
      end
      ST_MUL_H: begin
        mul_a = MUL_W'(rate_r[RATE_W-1:MUL_W]);
        mul_b = interval_r;
      end
      ST_REC_L: begin
        mul_a = m_val[MUL_W-1:0];
        mul_b = REC_C;
      end
      ST_REC_H: begin
        mul_a = MUL_W'(m_val[M_W-1:MUL_W]);
        mul_b = REC_C;
      end
      ST_FIX: begin
        mul_a = est_r;
        mul_b = MUL_W'(US_Q8_ODD);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    need_nxt      = need_r;
    rate_nxt      = rate_r;
    last_nxt      = last_r;
    first_nxt     = first_r;
    interval_nxt  = interval_r;
    res_valid_nxt = res_valid_r;
    div_go_nxt    = 1'b0;
    res_nxt       = res_r;
    prod_nxt      = prod_r;
    elapsed_nxt   = elapsed_r;
    rec_nxt       = rec_r;
    est_nxt       = est_r;

    if (res_valid_r && out_pop) begin
      res_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (q_cmd.kind == CMD_TICK) begin
            tick_nxt = (tick_r == '1) ? tick_r : tick_r + 1'b1;
            res_valid_nxt          = 1'b1;
            res_nxt.is_ready       = (tick_nxt >= need_r);
            res_nxt.required_count = REQ_W'(need_r);
            res_nxt.rate_estimate  = rate_r;
          end else if (tick_r >= need_r) begin
            elapsed_nxt = now_cut - last_r;
            last_nxt    = now_cut;
            state_nxt   = ST_MUL_T;
          end else begin
            res_valid_nxt          = 1'b1;
            res_nxt.is_ready       = 1'b0;
            res_nxt.required_count = REQ_W'(need_r);
            res_nxt.rate_estimate  = rate_r;
          end
        end
      end
      ST_MUL_T: begin
        prod_nxt   = PROD_W'(mul_p);
        div_go_nxt = 1'b1;
        state_nxt  = ST_DIV_R;
      end
      ST_DIV_R: begin
        if (div_done) begin
          rate_nxt  = first_r ? div_quo : blend_sum[RATE_W+1:2];
          first_nxt = 1'b0;
          tick_nxt  = '0;
          state_nxt = ST_MUL_L;
        end
      end
      ST_MUL_L: begin
        prod_nxt  = PROD_W'(mul_p);
        state_nxt = ST_MUL_H;
      end
      ST_MUL_H: begin
        prod_nxt  = prod_r + (PROD_W'(mul_p) << MUL_W) + PROD_W'(US_Q8_HALF);
        state_nxt = ST_REC_L;
      end
      ST_REC_L: begin
        if (m_sat) begin
          need_nxt               = NEED_MAX;
          res_valid_nxt          = 1'b1;
          res_nxt.is_ready       = 1'b0;
          res_nxt.required_count = REQ_W'(NEED_MAX);
          res_nxt.rate_estimate  = rate_r;
          state_nxt              = ST_IDLE;
        end else begin
          rec_nxt   = mul_p;
          state_nxt = ST_REC_H;
        end
      end
      ST_REC_H: begin
        est_nxt   = rec_sum[REC_SHIFT+MUL_W-1:REC_SHIFT];
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        need_nxt               = need_calc;
        res_valid_nxt          = 1'b1;
        res_nxt.is_ready       = (need_calc == '0);
        res_nxt.required_count = REQ_W'(need_calc);
        res_nxt.rate_estimate  = rate_r;
        state_nxt              = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_valid) begin
      case (cfg_index)
        CFG_INTERVAL_US: begin
          interval_nxt = cfg_data;
        end
        CFG_INITIAL_REQUIRED: begin
          need_nxt = COUNT_WIDTH'(cfg_data[REQ_W-1:0]);
          tick_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      need_r      <= COUNT_WIDTH'(INIT_REQUIRED_RESET);
      rate_r      <= '0;
      last_r      <= '0;
      first_r     <= 1'b1;
      interval_r  <= INTERVAL_RESET;
      res_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      need_r      <= need_nxt;
      rate_r      <= rate_nxt;
      last_r      <= last_nxt;
      first_r     <= first_nxt;
      interval_r  <= interval_nxt;
      res_valid_r <= res_valid_nxt;
      div_go_r    <= div_go_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    prod_r    <= prod_nxt;
    elapsed_r <= elapsed_nxt;
    rec_r     <= rec_nxt;
    est_r     <= est_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/adaptive_tick_prescaler.sv =====
// Channel   Ports                                   Transfer when
// input     in_push, in_full, in_item               in_push && !in_full
// result    out_pop, out_empty, out_item            out_pop && !out_empty
// config    cfg_valid, cfg_ready, cfg_index, data   cfg_valid && cfg_ready
//
// A tick, or a rearm that is not yet ready, is answered in ST_IDLE. An
// acting rearm goes through ST_MUL_T, a 40-step radix-2 divider pass for
// the measured rate (cut short on overflow), then ST_MUL_L, ST_MUL_H,
// ST_REC_L, ST_REC_H and ST_FIX on one 32x32 multiplier; the last three
// are the reciprocal divide by the fixed microsecond scale and its correction.
// A two-entry queue takes input items while the back end works or a result
// waits. Reset is synchronous and active low; it needs no clearing pass.
`default_nettype none

module adaptive_tick_prescaler
  import atp_pkg::*;
#(
  parameter int COUNT_WIDTH = 24,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  input  wire in_item_t             in_item,
  output logic                      in_full,
  input  wire logic                 out_pop,
  output out_item_t                 out_item,
  output logic                      out_empty,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  assign cfg_ready = 1'b1;

  atp_front u_atp_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  atp_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_atp_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/atp_checker.sv =====
`default_nettype none

module atp_checker
  import atp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_full,
  input wire logic      out_pop,
  input wire out_item_t out_item,
  input wire logic      out_empty
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result side not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result changed before its transfer");

  a_zero_required_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.required_count == '0) |-> out_item.is_ready)
    else $error("zero required count reported as not ready");

endmodule

bind adaptive_tick_prescaler atp_checker u_atp_checker (.*);

`default_nettype wire

// ===== dv/tb_adaptive_tick_prescaler.sv =====
`default_nettype none

module tb_adaptive_tick_prescaler;
  import atp_pkg::*;

  localparam logic [REQ_W-1:0]     COUNT_MAX   = '1;
  localparam logic [RATE_W-1:0]    RATE_MAX    = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int                   STALL_LIMIT = 4000;
  localparam int                   SETTLE      = 200;
  localparam int                   PHASES      = 7;
  localparam int                   PHASE_ITEMS = 100;

  typedef enum bit {
    ROW_ITEM = 1'b0,
    ROW_REG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DAT_W-1:0]  data;
  } script_row_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_push   = 1'b0;
  in_item_t             in_item   = '0;
  logic                 in_full;
  logic                 out_pop   = 1'b0;
  out_item_t            out_item;
  logic                 out_empty;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  logic [REQ_W-1:0]  ticks_seen     = '0;
  logic [REQ_W-1:0]  ticks_needed   = INIT_REQUIRED_RESET;
  logic [RATE_W-1:0] rate_q8        = '0;
  logic [NOW_W-1:0]  last_stamp     = '0;
  bit                awaiting_first = 1'b1;
  logic [NOW_W-1:0]  interval_reg   = INTERVAL_RESET;

  out_item_t   due_reports[$];
  script_row_t script[$];
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  int          pop_hold     = 0;
  bit          steady       = 1'b0;
  bit          cfg_held     = 1'b0;

  adaptive_tick_prescaler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [RATE_W-1:0] measured_rate(logic [REQ_W-1:0] ticks,
                                                      logic [NOW_W-1:0] elapsed);
    logic [63:0] q;
    if (elapsed == '0) return RATE_MAX;
    q = 64'(ticks) * 64'(US_Q8) / 64'(elapsed);
    return (q > 64'(RATE_MAX)) ? RATE_MAX : q[RATE_W-1:0];
  endfunction

  function automatic logic [REQ_W-1:0] ticks_for_interval(logic [RATE_W-1:0] rate,
                                                          logic [NOW_W-1:0] span_us);
    logic [63:0] q8;
    logic [63:0] whole;
    logic [63:0] part;
    logic [63:0] req;
    q8    = 64'(US_Q8);
    whole = 64'(rate) / q8;
    part  = 64'(rate) % q8;
    req   = whole * 64'(span_us) + (part * 64'(span_us) + 64'(US_Q8_HALF)) / q8;
    return (req > 64'(COUNT_MAX)) ? COUNT_MAX : req[REQ_W-1:0];
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t         r;
    logic [RATE_W-1:0] fresh;
    logic [63:0]       blend;
    if (it.mode == CMD_TICK) begin
      if (ticks_seen != COUNT_MAX) ticks_seen = ticks_seen + 1'b1;
    end else if (ticks_seen >= ticks_needed) begin
      fresh      = measured_rate(ticks_seen, it.now_time - last_stamp);
      last_stamp = it.now_time;
      if (awaiting_first) begin
        rate_q8        = fresh;
        awaiting_first = 1'b0;
      end else begin
        blend   = (64'(rate_q8) + 64'd3 * 64'(fresh)) >> 2;
        rate_q8 = blend[RATE_W-1:0];
      end
      ticks_seen   = '0;
      ticks_needed = ticks_for_interval(rate_q8, interval_reg);
    end
    r.is_ready       = (ticks_seen >= ticks_needed);
    r.required_count = ticks_needed;
    r.rate_estimate  = rate_q8;
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    case (idx)
      CFG_INTERVAL_US: begin
        interval_reg = val;
      end
      CFG_INITIAL_REQUIRED: begin
        ticks_needed = val[REQ_W-1:0];
        ticks_seen   = '0;
      end
      default: begin
      end
    endcase
  endfunction

  // Elapsed time for a rearm, mostly sized so that the next required count stays small.
  function automatic logic [NOW_W-1:0] pick_span();
    logic [63:0] span;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1 || ticks_seen == '0 || interval_reg == '0) return $urandom();
    span = 64'(ticks_seen) * 64'(interval_reg) / 64'($urandom_range(1, 12));
    span = span * 64'($urandom_range(75, 125)) / 64'd100;
    if (span == '0 || span > 64'hFFFF_FFFF) return $urandom();
    return span[NOW_W-1:0];
  endfunction

  function automatic void add_item(cmd_kind_e m, logic [NOW_W-1:0] t);
    script_row_t row;
    row               = '0;
    row.kind          = ROW_ITEM;
    row.item.mode     = m;
    row.item.now_time = t;
    script.push_back(row);
  endfunction

  function automatic void add_checked(cmd_kind_e m, logic [NOW_W-1:0] t, logic rdy,
                                      logic [REQ_W-1:0] req, logic [RATE_W-1:0] rate);
    int last;
    add_item(m, t);
    last = script.size() - 1;
    script[last].typed               = 1'b1;
    script[last].want.is_ready       = rdy;
    script[last].want.required_count = req;
    script[last].want.rate_estimate  = rate;
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    script_row_t row;
    row      = '0;
    row.kind = ROW_REG;
    row.idx  = idx;
    row.data = val;
    script.push_back(row);
  endfunction

  task automatic drain();
    in_push <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    drain();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    cfg_held = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t want = '0);
    out_item_t pred;
    if (cfg_held) begin
      cfg_valid <= 1'b0;
      cfg_held = 1'b0;
    end
    if (!steady && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pred = apply_item(it);
    due_reports.push_back(typed ? want : pred);
  endtask

  initial begin
    in_item_t    it;
    int unsigned pick;
    int          stuck;
    logic [NOW_W-1:0] span_us;
    logic [REQ_W-1:0] start_req;

    add_checked(CMD_TICK,  32'h0000_0000, 1'b0, 24'd100, 40'd0);
    add_checked(CMD_REARM, 32'hFFFF_FFFF, 1'b0, 24'd100, 40'd0);
    add_reg(CFG_INITIAL_REQUIRED, 32'hFF00_0002);
    add_checked(CMD_TICK,  32'hFFFF_FFFF, 1'b0, 24'd2, 40'd0);
    add_checked(CMD_TICK,  32'h0000_0000, 1'b1, 24'd2, 40'd0);
    add_checked(CMD_REARM, 32'h0000_0000, 1'b0, COUNT_MAX, RATE_MAX);
    add_checked(CMD_REARM, 32'h0000_3039, 1'b0, COUNT_MAX, RATE_MAX);
    add_reg(CFG_INTERVAL_US, 32'h0000_0000);
    add_reg(CFG_INITIAL_REQUIRED, 32'h0000_0001);
    add_checked(CMD_TICK,  32'h5555_5555, 1'b1, 24'd1, RATE_MAX);
    add_item(CMD_REARM, 32'h0000_03E8);
    add_item(CMD_REARM, 32'h0000_03E8);
    add_item(CMD_REARM, 32'hFFFF_FF00);
    add_item(CMD_REARM, 32'h0000_0100);
    add_reg(CFG_SPARE_2, 32'hFFFF_FFFF);
    add_reg(CFG_SPARE_3, 32'h0000_0000);
    add_reg(CFG_INTERVAL_US, 32'hFFFF_FFFF);
    add_reg(CFG_INITIAL_REQUIRED, 32'h00FF_FFFF);
    add_item(CMD_TICK,  32'hAAAA_AAAA);
    add_item(CMD_REARM, 32'h0000_0000);
    add_reg(CFG_INTERVAL_US, 32'd10000);
    add_reg(CFG_INITIAL_REQUIRED, 32'd3);
    add_item(CMD_TICK,  32'h0000_0000);
    add_item(CMD_TICK,  32'hFFFF_FFFF);
    add_item(CMD_TICK,  32'h1234_5678);
    add_item(CMD_REARM, 32'h0000_7630);
    add_item(CMD_TICK,  32'h8000_0000);
    add_item(CMD_REARM, 32'h7FFF_FFFF);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_item(script[i].item, script[i].typed, script[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      steady = (phase == PHASES - 1);
      case (phase)
        0: begin span_us = 32'd10000;      start_req = 24'd5;     end
        1: begin span_us = 32'd1;          start_req = 24'd0;     end
        2: begin span_us = 32'hFFFF_FFFF;  start_req = 24'd3;     end
        3: begin span_us = 32'd0;          start_req = 24'd2;     end
        4: begin
          span_us   = $urandom_range(1, 100000);
          start_req = REQ_W'($urandom_range(1, 10));
        end
        5: begin span_us = 32'd1000;       start_req = COUNT_MAX; end
        default: begin span_us = 32'd250000; start_req = 24'd4;   end
      endcase
      write_reg(CFG_INTERVAL_US, span_us);
      write_reg(CFG_INITIAL_REQUIRED, {8'($urandom()), start_req});
      stuck = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ticks_seen < ticks_needed) stuck++;
        else stuck = 0;
        if (stuck > 40 && ticks_needed > 24'd64) begin
          write_reg(CFG_INITIAL_REQUIRED,
                    {8'($urandom()), REQ_W'($urandom_range(0, 6))});
          stuck = 0;
        end else if (!steady && due_reports.size() != 0 && $urandom_range(0, 49) == 0) begin
          drain();
        end
        pick        = $urandom_range(0, 99);
        it.now_time = $urandom();
        if (ticks_seen >= ticks_needed && pick < 60) begin
          it.mode     = CMD_REARM;
          it.now_time = last_stamp + pick_span();
        end else if (ticks_seen < ticks_needed && pick < 8) begin
          it.mode = CMD_REARM;
        end else begin
          it.mode = CMD_TICK;
        end
        send_item(it);
      end
    end

    drain();
    if (cfg_held) cfg_valid <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (due_reports.size() == 0) begin
        mismatches++;
        $error("unexpected result transfer: %p", out_item);
      end else begin
        want = due_reports.pop_front();
        if (out_item.is_ready !== want.is_ready) begin
          mismatches++;
          $error("is_ready: expected %0d, got %0d", want.is_ready, out_item.is_ready);
        end
        if (out_item.required_count !== want.required_count) begin
          mismatches++;
          $error("required_count: expected %0d, got %0d",
                 want.required_count, out_item.required_count);
        end
        if (out_item.rate_estimate !== want.rate_estimate) begin
          mismatches++;
          $error("rate_estimate: expected %0d, got %0d",
                 want.rate_estimate, out_item.rate_estimate);
        end
      end
    end
    if (pop_hold != 0) begin
      pop_hold--;
      out_pop <= 1'b0;
    end else if (!steady && $urandom_range(0, 9) == 0) begin
      pop_hold = $urandom_range(0, 7);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
